// ===== hw/rtl/meac_pkg.sv =====
// Shared types and constants for the mesh element area and centroid block.
`default_nettype none

package meac_pkg;

    // Fixed field widths of the stream payload
    localparam int FIELD_W  = 16;
    localparam int AREA_W   = 42;
    localparam int DEPTH_W  = 16;
    localparam int CNT_W    = 3;
    localparam int STAT_W   = 2;

    localparam int IN_DATA_W  = 8 * FIELD_W;
    localparam int OUT_DATA_W = ((AREA_W + 2 * FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - AREA_W - 2 * FIELD_W;

    // Parameter defaults
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Depth factor after reset: 1.0 in Q8.8
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd256;

    // Vertex counts that are handled
    localparam logic [CNT_W-1:0] VC_TRI  = 3'd3;
    localparam logic [CNT_W-1:0] VC_QUAD = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEGEN     = 2'd2;

    // Side data that rides along the divider pipeline
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [STAT_W-1:0] status;
        logic              neg_x;
        logic              neg_y;
    } t_tag;

endpackage

`default_nettype wire

// ===== hw/rtl/meac_div.sv =====
// Pipelined radix-2 restoring divider, two numerators over one shared divisor.
`default_nettype none

module meac_div #(
    parameter int Q_W   = meac_pkg::COORD_WIDTH_DEF,
    parameter int NUM_W = 3 * meac_pkg::COORD_WIDTH_DEF + 6,
    parameter int DEN_W = 2 * meac_pkg::COORD_WIDTH_DEF + 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NUM_W-1:0]  i_num_x,
    input  logic [NUM_W-1:0]  i_num_y,
    input  logic [DEN_W-1:0]  i_den,
    input  meac_pkg::t_tag    i_tag,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [Q_W-1:0]    o_quo_x,
    output logic [Q_W-1:0]    o_quo_y,
    output meac_pkg::t_tag    o_tag
);

    // One quotient bit per stage, most significant first
    logic [Q_W-1:0]   r_v;
    logic [NUM_W-1:0] r_rx  [Q_W];
    logic [NUM_W-1:0] r_ry  [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_qx  [Q_W];
    logic [Q_W-1:0]   r_qy  [Q_W];
    meac_pkg::t_tag   r_tag [Q_W];

    logic [NUM_W-1:0] rx_src  [Q_W];
    logic [NUM_W-1:0] ry_src  [Q_W];
    logic [DEN_W-1:0] den_src [Q_W];
    logic [Q_W-1:0]   qx_src  [Q_W];
    logic [Q_W-1:0]   qy_src  [Q_W];
    meac_pkg::t_tag   tag_src [Q_W];
    logic [Q_W-1:0]   v_src;

    logic [NUM_W-1:0] n_rx [Q_W];
    logic [NUM_W-1:0] n_ry [Q_W];
    logic [Q_W-1:0]   n_qx [Q_W];
    logic [Q_W-1:0]   n_qy [Q_W];
    logic [Q_W-1:0]   en;

    assign v_src = {r_v[Q_W-2:0], i_valid};

    // Stage inputs, trial subtract and stage enables
    always_comb begin
        logic [NUM_W:0] sub;
        logic [NUM_W:0] dx;
        logic [NUM_W:0] dy;
        rx_src[0]  = i_num_x;
        ry_src[0]  = i_num_y;
        den_src[0] = i_den;
        qx_src[0]  = '0;
        qy_src[0]  = '0;
        tag_src[0] = i_tag;
        for (int k = 1; k < Q_W; k++) begin
            rx_src[k]  = r_rx[k-1];
            ry_src[k]  = r_ry[k-1];
            den_src[k] = r_den[k-1];
            qx_src[k]  = r_qx[k-1];
            qy_src[k]  = r_qy[k-1];
            tag_src[k] = r_tag[k-1];
        end
        for (int k = 0; k < Q_W; k++) begin
            sub     = {1'b0, NUM_W'(den_src[k]) << (Q_W - 1 - k)};
            dx      = {1'b0, rx_src[k]} - sub;
            dy      = {1'b0, ry_src[k]} - sub;
            n_rx[k] = dx[NUM_W] ? rx_src[k] : dx[NUM_W-1:0];
            n_ry[k] = dy[NUM_W] ? ry_src[k] : dy[NUM_W-1:0];
            n_qx[k] = qx_src[k] | (Q_W'(!dx[NUM_W]) << (Q_W - 1 - k));
            n_qy[k] = qy_src[k] | (Q_W'(!dy[NUM_W]) << (Q_W - 1 - k));
            // a stage moves when the output is ready or it or any stage after it is empty
            en[k]   = i_ready || ((~r_v >> k) != '0);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < Q_W; k++) begin
                if (en[k]) begin
                    r_v[k] <= v_src[k];
                end
            end
        end
    end

    // Partial remainders, quotients and side data
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (en[k]) begin
                r_rx[k]  <= n_rx[k];
                r_ry[k]  <= n_ry[k];
                r_den[k] <= den_src[k];
                r_qx[k]  <= n_qx[k];
                r_qy[k]  <= n_qy[k];
                r_tag[k] <= tag_src[k];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[Q_W-1];
    assign o_quo_x = r_qx[Q_W-1];
    assign o_quo_y = r_qy[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/mesh_element_area_centroid.sv =====
// Top level: streaming mesh element area and centroid pipeline.
`default_nettype none

// Takes one 2D element per beat (vertex count in tuser, four Q8.8 vertices in
// tdata) and returns one beat with the depth-scaled area, the centroid and a
// status. A new element can be taken every clock unless a stall has filled the
// pipeline; results leave in order after passing the input register, five
// arithmetic stages (products, sums, magnitudes, weighting multiplies,
// numerator and area scaling), then one stage per quotient bit in
// the centroid divider, then the output register. Every stage has its own
// valid bit and loads when it or any later stage is empty, so bubbles close up
// during a stall.
// Unsupported vertex counts return status 1, quads with zero total sub-triangle
// area return status 2; both with zero area and centroid. The depth register
// is written through the cfg channel, which is always ready.
module mesh_element_area_centroid #(
    parameter int COORD_WIDTH = meac_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = meac_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // x0, y0, x1, y1, x2, y2, x3, y3 (16 bits each)
    input  logic [meac_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // vertex_count
    input  logic [meac_pkg::CNT_W-1:0]         i_s_tuser,
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // area_out (42), centroid_x (16), centroid_y (16), zero pad
    output logic [meac_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // status
    output logic [meac_pkg::STAT_W-1:0]        o_m_tuser,
    // depth register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [meac_pkg::DEPTH_W-1:0]       i_cfg_data
);

    localparam int CW  = (COORD_WIDTH > meac_pkg::FIELD_W) ? meac_pkg::FIELD_W : COORD_WIDTH;
    localparam int EW  = CW + 1;             // coordinate sum or difference
    localparam int PW  = 2 * CW + 2;         // one cross term
    localparam int SW  = 2 * CW + 4;         // sum of cross terms
    localparam int MW  = 2 * CW + 2;         // twice-area magnitude
    localparam int TW  = CW + 2;             // sum of three coordinates
    localparam int NPW = MW + 1 + TW;        // weight times coordinate sum
    localparam int NW  = NPW + 1;            // centroid numerator
    localparam int DW  = MW + 3;             // centroid divisor
    localparam int AP  = MW + meac_pkg::DEPTH_W;
    localparam int AXW = (AP + 7 > meac_pkg::AREA_W) ? AP + 7 : meac_pkg::AREA_W + 1;
    localparam int SH  = 2 * FRAC_BITS - 7;
    localparam int SHL = (SH < 0) ? -SH : 0;
    localparam int SHR = (SH > 0) ? SH : 0;

    function automatic logic signed [EW-1:0] f_add(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        return EW'(a) + EW'(b);
    endfunction

    function automatic logic signed [EW-1:0] f_sub(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        return EW'(a) - EW'(b);
    endfunction

    function automatic logic signed [PW-1:0] f_mul(input logic signed [EW-1:0] a,
                                                   input logic signed [EW-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    function automatic logic signed [TW-1:0] f_sum3(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b,
                                                    input logic signed [CW-1:0] c);
        return TW'(a) + TW'(b) + TW'(c);
    endfunction

    function automatic logic [MW-1:0] f_abs(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] m;
        m = (v < 0) ? -v : v;
        return m[MW-1:0];
    endfunction

    function automatic logic signed [NPW-1:0] f_wmul(input logic [MW-1:0] w,
                                                     input logic signed [TW-1:0] s);
        return NPW'($signed({1'b0, w})) * NPW'(s);
    endfunction

    // ---------------------------------------------------------------
    // Depth register
    logic [meac_pkg::DEPTH_W-1:0] r_depth;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= meac_pkg::DEPTH_RESET;
        end else if (i_cfg_valid) begin
            r_depth <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Stage enables: a stage loads when empty or when the next one loads
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_o;
    logic div_ready;
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v, r_o_v;

    assign en_o       = !r_o_v || i_m_tready;
    assign en_f       = !r_f_v || div_ready;
    assign en_e       = !r_e_v || en_f;
    assign en_d       = !r_d_v || en_e;
    assign en_c       = !r_c_v || en_d;
    assign en_b       = !r_b_v || en_c;
    assign en_a       = !r_a_v || en_b;
    assign o_s_tready = en_a;

    // Front valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_s_tvalid;
            if (en_b) r_b_v <= r_a_v;
            if (en_c) r_c_v <= r_b_v;
            if (en_d) r_d_v <= r_c_v;
            if (en_e) r_e_v <= r_d_v;
            if (en_f) r_f_v <= r_e_v;
        end
    end

    // ---------------------------------------------------------------
    // Stage A: input register, coordinates cut to the active width
    logic [meac_pkg::CNT_W-1:0] r_a_cnt;
    logic signed [CW-1:0]       r_a_x [4];
    logic signed [CW-1:0]       r_a_y [4];

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_cnt <= i_s_tuser;
            for (int k = 0; k < 4; k++) begin
                r_a_x[k] <= i_s_tdata[2*k*meac_pkg::FIELD_W +: CW];
                r_a_y[k] <= i_s_tdata[(2*k+1)*meac_pkg::FIELD_W +: CW];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage B: shoelace cross terms of triangles 0-1-2 and 0-2-3, diagonal terms
    logic [meac_pkg::CNT_W-1:0] r_b_cnt;
    logic signed [PW-1:0]       r_b_ta [3];
    logic signed [PW-1:0]       r_b_tb [3];
    logic signed [PW-1:0]       r_b_tq [2];
    logic signed [TW-1:0]       r_b_sx1, r_b_sy1, r_b_sx2, r_b_sy2;

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_cnt   <= r_a_cnt;
            r_b_ta[0] <= f_mul(f_sub(r_a_x[0], r_a_x[1]), f_add(r_a_y[0], r_a_y[1]));
            r_b_ta[1] <= f_mul(f_sub(r_a_x[1], r_a_x[2]), f_add(r_a_y[1], r_a_y[2]));
            r_b_ta[2] <= f_mul(f_sub(r_a_x[2], r_a_x[0]), f_add(r_a_y[2], r_a_y[0]));
            r_b_tb[0] <= f_mul(f_sub(r_a_x[0], r_a_x[2]), f_add(r_a_y[0], r_a_y[2]));
            r_b_tb[1] <= f_mul(f_sub(r_a_x[2], r_a_x[3]), f_add(r_a_y[2], r_a_y[3]));
            r_b_tb[2] <= f_mul(f_sub(r_a_x[3], r_a_x[0]), f_add(r_a_y[3], r_a_y[0]));
            r_b_tq[0] <= f_mul(f_sub(r_a_x[0], r_a_x[2]), f_sub(r_a_y[1], r_a_y[3]));
            r_b_tq[1] <= f_mul(f_sub(r_a_x[3], r_a_x[1]), f_sub(r_a_y[0], r_a_y[2]));
            r_b_sx1   <= f_sum3(r_a_x[0], r_a_x[1], r_a_x[2]);
            r_b_sy1   <= f_sum3(r_a_y[0], r_a_y[1], r_a_y[2]);
            r_b_sx2   <= f_sum3(r_a_x[0], r_a_x[2], r_a_x[3]);
            r_b_sy2   <= f_sum3(r_a_y[0], r_a_y[2], r_a_y[3]);
        end
    end

    // ---------------------------------------------------------------
    // Stage C: twice signed areas
    logic [meac_pkg::CNT_W-1:0] r_c_cnt;
    logic signed [SW-1:0]       r_c_sa, r_c_sb, r_c_d;
    logic signed [TW-1:0]       r_c_sx1, r_c_sy1, r_c_sx2, r_c_sy2;

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_cnt <= r_b_cnt;
            r_c_sa  <= SW'(r_b_ta[0]) + SW'(r_b_ta[1]) + SW'(r_b_ta[2]);
            r_c_sb  <= SW'(r_b_tb[0]) + SW'(r_b_tb[1]) + SW'(r_b_tb[2]);
            r_c_d   <= SW'(r_b_tq[0]) + SW'(r_b_tq[1]);
            r_c_sx1 <= r_b_sx1;
            r_c_sy1 <= r_b_sy1;
            r_c_sx2 <= r_b_sx2;
            r_c_sy2 <= r_b_sy2;
        end
    end

    // ---------------------------------------------------------------
    // Stage D: magnitudes and status decode
    logic [meac_pkg::STAT_W-1:0] n_d_status;
    logic                        n_d_quad;

    always_comb begin
        n_d_quad = 1'b0;
        unique case (r_c_cnt)
            meac_pkg::VC_TRI: begin
                n_d_status = meac_pkg::ST_OK;
            end
            meac_pkg::VC_QUAD: begin
                n_d_quad   = 1'b1;
                // weights are magnitudes, so their sum is zero only if both are
                n_d_status = (r_c_sa == '0 && r_c_sb == '0) ? meac_pkg::ST_DEGEN
                                                            : meac_pkg::ST_OK;
            end
            default: begin
                n_d_status = meac_pkg::ST_BAD_COUNT;
            end
        endcase
    end

    logic [meac_pkg::STAT_W-1:0] r_d_status;
    logic                        r_d_quad;
    logic [MW-1:0]               r_d_wa, r_d_wb, r_d_mag;
    logic signed [TW-1:0]        r_d_sx1, r_d_sy1, r_d_sx2, r_d_sy2;

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_status <= n_d_status;
            r_d_quad   <= n_d_quad;
            r_d_wa     <= f_abs(r_c_sa);
            r_d_wb     <= f_abs(r_c_sb);
            r_d_mag    <= n_d_quad ? f_abs(r_c_d) : f_abs(r_c_sa);
            r_d_sx1    <= r_c_sx1;
            r_d_sy1    <= r_c_sy1;
            r_d_sx2    <= r_c_sx2;
            r_d_sy2    <= r_c_sy2;
        end
    end

    // ---------------------------------------------------------------
    // Stage E: weighted coordinate sums, divisor 3*(wa+wb), area times depth
    logic [DW-1:0] wsum;
    assign wsum = DW'(r_d_wa) + DW'(r_d_wb);

    logic [meac_pkg::STAT_W-1:0] r_e_status;
    logic                        r_e_quad;
    logic signed [NPW-1:0]       r_e_nx1, r_e_nx2, r_e_ny1, r_e_ny2;
    logic [DW-1:0]               r_e_den;
    logic [AP-1:0]               r_e_ap;
    logic signed [TW-1:0]        r_e_sx1, r_e_sy1;

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_status <= r_d_status;
            r_e_quad   <= r_d_quad;
            r_e_nx1    <= f_wmul(r_d_wa, r_d_sx1);
            r_e_nx2    <= f_wmul(r_d_wb, r_d_sx2);
            r_e_ny1    <= f_wmul(r_d_wa, r_d_sy1);
            r_e_ny2    <= f_wmul(r_d_wb, r_d_sy2);
            r_e_den    <= (wsum << 1) + wsum;
            r_e_ap     <= AP'(r_d_mag) * AP'(r_depth);
            r_e_sx1    <= r_d_sx1;
            r_e_sy1    <= r_d_sy1;
        end
    end

    // ---------------------------------------------------------------
    // Stage F: numerator sign and magnitude, area scaling with saturation
    logic signed [NW-1:0]          num_x, num_y, mag_x, mag_y;
    logic [AXW-1:0]                area_ext;
    logic [meac_pkg::AREA_W-1:0]   area_sat;

    always_comb begin
        // a triangle divides its plain coordinate sum by three
        num_x    = r_e_quad ? NW'(r_e_nx1) + NW'(r_e_nx2) : NW'(r_e_sx1);
        num_y    = r_e_quad ? NW'(r_e_ny1) + NW'(r_e_ny2) : NW'(r_e_sy1);
        mag_x    = (num_x < 0) ? -num_x : num_x;
        mag_y    = (num_y < 0) ? -num_y : num_y;
        area_ext = (AXW'(r_e_ap) << SHL) >> SHR;
        area_sat = (|area_ext[AXW-1:meac_pkg::AREA_W]) ? '1
                                                       : area_ext[meac_pkg::AREA_W-1:0];
    end

    logic                    r_f_quad;
    logic [NW-1:0]           r_f_num_x, r_f_num_y;
    logic [DW-1:0]           r_f_den;
    meac_pkg::t_tag          r_f_tag;

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_f_quad       <= r_e_quad;
            r_f_num_x      <= mag_x;
            r_f_num_y      <= mag_y;
            r_f_den        <= r_e_quad ? r_e_den : DW'(3);
            r_f_tag.area   <= area_sat;
            r_f_tag.status <= r_e_status;
            r_f_tag.neg_x  <= (num_x < 0);
            r_f_tag.neg_y  <= (num_y < 0);
        end
    end

    // ---------------------------------------------------------------
    // Centroid divider
    logic            div_valid;
    logic [CW-1:0]   quo_x, quo_y;
    meac_pkg::t_tag  div_tag;

    meac_div #(
        .Q_W   (CW),
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .o_ready (div_ready),
        .i_num_x (r_f_num_x),
        .i_num_y (r_f_num_y),
        .i_den   (r_f_den),
        .i_tag   (r_f_tag),
        .o_valid (div_valid),
        .i_ready (en_o),
        .o_quo_x (quo_x),
        .o_quo_y (quo_y),
        .o_tag   (div_tag)
    );

    // ---------------------------------------------------------------
    // Output register: restore sign, zero the fields of a rejected element
    logic signed [CW:0] qs_x, qs_y;

    always_comb begin
        qs_x = $signed({1'b0, quo_x});
        qs_y = $signed({1'b0, quo_y});
        if (div_tag.neg_x) qs_x = -qs_x;
        if (div_tag.neg_y) qs_y = -qs_y;
    end

    logic [meac_pkg::AREA_W-1:0]  r_o_area;
    logic [meac_pkg::FIELD_W-1:0] r_o_cx, r_o_cy;
    logic [meac_pkg::STAT_W-1:0]  r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en_o) begin
            r_o_v <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_status <= div_tag.status;
            if (div_tag.status == meac_pkg::ST_OK) begin
                r_o_area <= div_tag.area;
                r_o_cx   <= meac_pkg::FIELD_W'(qs_x);
                r_o_cy   <= meac_pkg::FIELD_W'(qs_y);
            end else begin
                r_o_area <= '0;
                r_o_cx   <= '0;
                r_o_cy   <= '0;
            end
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = {{meac_pkg::OUT_PAD_W{1'b0}}, r_o_cy, r_o_cx, r_o_area};
    assign o_m_tuser  = r_o_status;

    // ---------------------------------------------------------------
    // Checks

    // an accepted quad never reaches the divider with a zero divisor
    a_quad_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_v && r_f_quad && r_f_tag.status == meac_pkg::ST_OK |-> r_f_den != '0)
        else $error("quad entering divider with zero divisor");

    // a held input stage keeps its element while the next stage is blocked
    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v && !en_b |=> r_a_v && $stable(r_a_x[0]) && $stable(r_a_cnt))
        else $error("input stage lost its element during a stall");

    // an error status carries zero area and centroid
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != meac_pkg::ST_OK |->
            o_m_tdata[meac_pkg::AREA_W + 2*meac_pkg::FIELD_W - 1:0] == '0)
        else $error("error result with nonzero fields");

endmodule

`default_nettype wire
